### design/sru_pkg.sv
// Shared types and constants for the SART row update block.
`default_nettype none

package sru_pkg;

    localparam int VALUE_W     = 32;
    localparam int WEIGHT_W    = 32;
    localparam int ACC_W       = 64;
    localparam int WEIGHT_FRAC = 24;
    localparam int LAMBDA_W    = 16;
    localparam int LAMBDA_FRAC = 14;
    localparam int QLIM_W      = 47;
    localparam int CNT_W       = $clog2(ACC_W);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET   = 16'd16384;
    localparam logic [PADDR_W-1:0]  REG_LAMBDA_ADDR = 3'd0;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_BWD = 1'b1
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic acc;
        logic prep;
        logic load;
        logic step;
        logic post;
        logic post2;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic tot_zero;
        logic op_bwd;
    } t_sts;

endpackage

`default_nettype wire

### design/sru_ctrl.sv
// Controller state machine: row accumulation, row-end division sequence, result hand-off.
`default_nettype none

module sru_ctrl
    import sru_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_last,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_ACC   = 8'b0000_0001,
        S_DRAIN = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_POST  = 8'b0010_0000,
        S_POST2 = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;
    logic             acc;

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_vld;
    assign acc         = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        o_cmd.acc = acc;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_ACC: begin
                if (acc && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.tot_zero ? S_EMIT : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = i_sts.op_bwd ? S_POST2 : S_EMIT;
            end
            S_POST2: begin
                o_cmd.post2 = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

### design/sru_dp.sv
// Datapath: multiply-accumulate, row-end numerator, restoring divider, update and output register.
`default_nettype none

module sru_dp
    import sru_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  t_cmd                      i_cmd,
    input  wire  [LAMBDA_W-1:0]       i_lambda,
    input  wire                       i_op,
    input  wire  signed [VALUE_W-1:0] i_gathered_value,
    input  wire  [WEIGHT_W-1:0]       i_weight,
    input  wire  signed [VALUE_W-1:0] i_base_value,
    input  wire                       i_last,
    output t_sts                      o_sts,
    output logic                      o_row_kind,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic signed [VALUE_W-1:0] o_delta_value
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]        VAL_MAX_MAG = ACC_W'((64'd1 << (VALUE_W-1)) - 64'd1);
    localparam logic [ACC_W-1:0]        QLIM = ACC_W'(64'd1 << (QLIM_W-1));
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam int UPD_W = QLIM_W + LAMBDA_W;
    localparam int SUM_W = UPD_W - LAMBDA_FRAC + 2;

    // Sign and magnitude to a saturated signed value
    function automatic logic signed [VALUE_W-1:0] sat_sm(input logic neg,
                                                         input logic [ACC_W-1:0] mag);
        logic signed [VALUE_W-1:0] res;
        if (neg) begin
            if (mag > VAL_MAX_MAG) begin
                res = VAL_MIN;
            end else begin
                res = -$signed(mag[VALUE_W-1:0]);
            end
        end else begin
            if (mag > VAL_MAX_MAG) begin
                res = VAL_MAX;
            end else begin
                res = $signed(mag[VALUE_W-1:0]);
            end
        end
        return res;
    endfunction

    logic signed [ACC_W-1:0]   r_prod;
    logic                      r_prod_vld;
    logic signed [ACC_W-1:0]   r_wsum;
    logic [ACC_W-1:0]          r_tot;
    logic                      r_op;
    logic signed [VALUE_W-1:0] r_base;
    logic signed [ACC_W-1:0]   r_num;
    logic [ACC_W-1:0]          r_dvs;
    logic [ACC_W-1:0]          r_rem;
    logic [ACC_W-1:0]          r_quo;
    logic                      r_neg;
    logic [UPD_W-1:0]          r_upd;
    logic signed [VALUE_W-1:0] r_res;
    logic signed [VALUE_W-1:0] r_delta;
    logic                      r_out_kind;
    logic signed [VALUE_W-1:0] r_out_res;
    logic signed [VALUE_W-1:0] r_out_delta;

    // multiply-accumulate
    logic signed [VALUE_W:0]          gv_s;
    logic signed [WEIGHT_W:0]         w_s;
    logic signed [VALUE_W+WEIGHT_W+1:0] prod_full;
    logic [ACC_W:0]                   tot_sum;
    logic signed [ACC_W:0]            wsum_sum;
    logic signed [ACC_W-1:0]          wsum_sat;

    assign gv_s      = {i_gathered_value[VALUE_W-1], i_gathered_value};
    assign w_s       = {1'b0, i_weight};
    assign prod_full = gv_s * w_s;
    assign tot_sum   = {1'b0, r_tot} + (ACC_W+1)'(i_weight);
    assign wsum_sum  = {r_wsum[ACC_W-1], r_wsum} + {r_prod[ACC_W-1], r_prod};

    always_comb begin
        if (wsum_sum[ACC_W] != wsum_sum[ACC_W-1]) begin
            wsum_sat = wsum_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            wsum_sat = wsum_sum[ACC_W-1:0];
        end
    end

    // row end: forward numerator and projection sum
    logic signed [ACC_W-1:0] base_sh;
    logic signed [ACC_W:0]   num_diff;
    logic signed [ACC_W-1:0] fwd_num;
    logic [ACC_W-1:0]        wsum_mag;
    logic signed [VALUE_W-1:0] res_fwd;
    logic [ACC_W-1:0]        num_mag;

    assign base_sh  = {{(ACC_W-VALUE_W-WEIGHT_FRAC){r_base[VALUE_W-1]}}, r_base,
                       {WEIGHT_FRAC{1'b0}}};
    assign num_diff = {base_sh[ACC_W-1], base_sh} - {r_wsum[ACC_W-1], r_wsum};
    assign wsum_mag = r_wsum[ACC_W-1] ? ACC_W'(-r_wsum) : r_wsum;
    assign res_fwd  = sat_sm(r_wsum[ACC_W-1], wsum_mag >> WEIGHT_FRAC);
    assign num_mag  = r_num[ACC_W-1] ? ACC_W'(-r_num) : r_num;

    always_comb begin
        if (r_wsum == ACC_MIN) begin
            // most negative subtrahend: non-negative base saturates, else doubled offset
            if (!base_sh[ACC_W-1]) begin
                fwd_num = ACC_MAX;
            end else begin
                fwd_num = {base_sh[ACC_W-2:0], 1'b0} ^ ACC_MIN;
            end
        end else if (num_diff[ACC_W] != num_diff[ACC_W-1]) begin
            fwd_num = num_diff[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            fwd_num = num_diff[ACC_W-1:0];
        end
    end

    // restoring divider step
    logic [ACC_W:0] trial;
    logic [ACC_W:0] trial_diff;
    logic           trial_ge;

    assign trial      = {r_rem, r_quo[ACC_W-1]};
    assign trial_diff = trial - {1'b0, r_dvs};
    assign trial_ge   = (trial >= {1'b0, r_dvs});

    // backward update
    logic [QLIM_W-1:0]         q_clamp;
    logic [UPD_W-LAMBDA_FRAC-1:0] upd_mag;
    logic signed [SUM_W-1:0]   upd_s;
    logic signed [SUM_W-1:0]   bwd_sum;
    logic signed [VALUE_W-1:0] res_bwd;

    assign q_clamp = (r_quo > QLIM) ? QLIM[QLIM_W-1:0] : r_quo[QLIM_W-1:0];
    assign upd_mag = r_upd[UPD_W-1:LAMBDA_FRAC];
    assign upd_s   = r_neg ? -$signed(SUM_W'(upd_mag)) : $signed(SUM_W'(upd_mag));
    assign bwd_sum = SUM_W'(r_base) + upd_s;

    always_comb begin
        if (bwd_sum[SUM_W-1]) begin
            res_bwd = '0;
        end else if (bwd_sum > SUM_W'(VAL_MAX)) begin
            res_bwd = VAL_MAX;
        end else begin
            res_bwd = bwd_sum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_wsum     <= '0;
            r_tot      <= '0;
        end else begin
            r_prod_vld <= i_cmd.acc;
            if (i_cmd.prep) begin
                r_wsum <= '0;
                r_tot  <= '0;
            end else begin
                if (r_prod_vld) begin
                    r_wsum <= wsum_sat;
                end
                if (i_cmd.acc) begin
                    r_tot <= tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_prod <= prod_full[ACC_W-1:0];
            if (i_last) begin
                r_op   <= i_op;
                r_base <= i_base_value;
            end
        end
        if (i_cmd.prep) begin
            r_num   <= (r_op == OP_BWD) ? r_wsum : fwd_num;
            r_dvs   <= r_tot;
            r_delta <= '0;
            if (r_op == OP_BWD) begin
                r_res <= r_base;
            end else begin
                r_res <= (r_tot == '0) ? '0 : res_fwd;
            end
        end
        if (i_cmd.load) begin
            r_neg <= r_num[ACC_W-1];
            r_quo <= num_mag;
            r_rem <= '0;
        end
        if (i_cmd.step) begin
            r_rem <= trial_ge ? trial_diff[ACC_W-1:0] : trial[ACC_W-1:0];
            r_quo <= {r_quo[ACC_W-2:0], trial_ge};
        end
        if (i_cmd.post) begin
            if (r_op == OP_BWD) begin
                r_upd <= q_clamp * i_lambda;
            end else begin
                r_delta <= sat_sm(r_neg, r_quo);
            end
        end
        if (i_cmd.post2) begin
            r_res <= res_bwd;
        end
        if (i_cmd.emit) begin
            r_out_kind  <= r_op;
            r_out_res   <= r_res;
            r_out_delta <= r_delta;
        end
    end

    assign o_sts.tot_zero = (r_tot == '0);
    assign o_sts.op_bwd   = (r_op == OP_BWD);
    assign o_row_kind     = r_out_kind;
    assign o_result_value = r_out_res;
    assign o_delta_value  = r_out_delta;

endmodule

`default_nettype wire

### design/sart_row_update.sv
// Top level of the SART row update: APB register, controller and datapath.
// Within a row one word is taken per cycle (multiply registered, then accumulated).
// After the last word a row passes drain, prep, load, the 64-step restoring divider and post;
// a backward row adds a second post step, and a zero weight sum goes from prep straight to emit.
// No word is taken from the last word of a row until its result enters the output register.
// Synchronous active-low reset clears both sums and the output valid flag, and sets lambda to 1.0.
`default_nettype none

module sart_row_update
    import sru_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire                       i_op,
    input  wire  signed [VALUE_W-1:0] i_gathered_value,
    input  wire  [WEIGHT_W-1:0]       i_weight,
    input  wire  signed [VALUE_W-1:0] i_base_value,
    input  wire                       i_last,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic                      o_row_kind,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic signed [VALUE_W-1:0] o_delta_value,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire  [PADDR_W-1:0]        paddr,
    input  wire  [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    logic [LAMBDA_W-1:0] r_lambda;
    t_cmd                cmd;
    t_sts                sts;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LAMBDA_ADDR) ? PDATA_W'(r_lambda) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= LAMBDA_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_LAMBDA_ADDR) begin
            r_lambda <= pwdata[LAMBDA_W-1:0];
        end
    end

    sru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    sru_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_lambda         (r_lambda),
        .i_op             (i_op),
        .i_gathered_value (i_gathered_value),
        .i_weight         (i_weight),
        .i_base_value     (i_base_value),
        .i_last           (i_last),
        .o_sts            (sts),
        .o_row_kind       (o_row_kind),
        .o_result_value   (o_result_value),
        .o_delta_value    (o_delta_value)
    );

endmodule

`default_nettype wire

### design/sru_chk.sv
// Port-level checker for the SART row update, bound to the top level.
`default_nettype none

module sru_chk
    import sru_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 i_op,
    input wire [VALUE_W-1:0]   i_gathered_value,
    input wire [WEIGHT_W-1:0]  i_weight,
    input wire [VALUE_W-1:0]   i_base_value,
    input wire                 i_last,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire                 o_row_kind,
    input wire [VALUE_W-1:0]   o_result_value,
    input wire [VALUE_W-1:0]   o_delta_value,
    input wire                 psel,
    input wire                 penable,
    input wire                 pwrite,
    input wire [PADDR_W-1:0]   paddr,
    input wire [PDATA_W-1:0]   pwdata,
    input wire [PDATA_W-1:0]   prdata,
    input wire                 pready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_row_kind) && $stable(o_result_value)
             && $stable(o_delta_value)))
        else $error("result word changed while stalled");

    // the row end blocks input for at least the drain and prep cycles
    a_row_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last) |=> (!o_in_ready ##1 !o_in_ready))
        else $error("input taken too soon after a row end");

    // backward results carry no residual
    a_bwd_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_kind) |-> (o_delta_value == '0))
        else $error("backward result with nonzero delta");

    // reset leaves the block ready and empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("reset state wrong");

endmodule

bind sart_row_update sru_chk u_chk (.*);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the SART row update block: directed rows, then random rows.
module testbench;
    import sru_pkg::*;

    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 115;
    localparam int PHASES         = 6;

    typedef logic signed [127:0] t_wide;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, 63'b0};
    localparam t_wide Q_LIM = t_wide'(1) <<< (QLIM_W - 1);

    typedef struct {
        t_op                       op;
        logic signed [VALUE_W-1:0] gathered;
        logic [WEIGHT_W-1:0]       weight;
        logic signed [VALUE_W-1:0] base;
        logic                      last;
    } t_in_word;

    typedef struct {
        t_op                       kind;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] delta;
    } t_row_result;

    typedef struct {
        t_in_word    word;
        bit          typed;
        t_row_result want;
    } t_plan_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_op = 1'b0;
    logic signed [VALUE_W-1:0] i_gathered_value = '0;
    logic [WEIGHT_W-1:0]       i_weight = '0;
    logic signed [VALUE_W-1:0] i_base_value = '0;
    logic                      i_last = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_row_kind;
    logic signed [VALUE_W-1:0] o_result_value;
    logic signed [VALUE_W-1:0] o_delta_value;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // Mirror of the block state
    logic signed [63:0]  acc_weighted = '0;
    logic [63:0]         acc_weight = '0;
    logic [LAMBDA_W-1:0] lambda_q14 = LAMBDA_RESET;

    t_row_result results_due[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          idling_on = 1'b0;

    sart_row_update dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_gathered_value (i_gathered_value),
        .i_weight         (i_weight),
        .i_base_value     (i_base_value),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_row_kind       (o_row_kind),
        .o_result_value   (o_result_value),
        .o_delta_value    (o_delta_value),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clamp64(t_wide v);
        if (v > S64_MAX) return S64_MAX;
        if (v < S64_MIN) return S64_MIN;
        return v[63:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] clamp_value(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (VALUE_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[VALUE_W-1:0];
        if (v < lo) return lo[VALUE_W-1:0];
        return v[VALUE_W-1:0];
    endfunction

    function automatic t_wide div_toward_zero(t_wide num, logic [63:0] den);
        t_wide d;
        d = {64'b0, den};
        if (den == 0) return '0;
        return num / d;
    endfunction

    // Fold one word into the row sums; on the last word produce the row result.
    function automatic bit fold_word(input t_in_word w, output t_row_result r);
        t_wide g;
        t_wide wt;
        t_wide base_q;
        t_wide num;
        t_wide q;
        t_wide lam;
        t_wide upd;
        logic [64:0] wsum;
        logic signed [VALUE_W-1:0] voxel;
        g = w.gathered;
        wt = {96'b0, w.weight};
        acc_weighted = clamp64(acc_weighted + g * wt);
        wsum = {1'b0, acc_weight} + {33'b0, w.weight};
        acc_weight = wsum[64] ? '1 : wsum[63:0];
        r.kind = w.op;
        r.value = '0;
        r.delta = '0;
        if (!w.last) return 1'b0;
        base_q = w.base;
        if (acc_weight != 0) begin
            if (w.op == OP_FWD) begin
                base_q = base_q <<< WEIGHT_FRAC;
                // at the negative rail the difference is defined as 2*base + 2^63
                if (acc_weighted == S64_MIN)
                    num = (base_q >= 0) ? t_wide'(S64_MAX) : 2 * base_q + (t_wide'(1) <<< 63);
                else
                    num = clamp64(base_q - acc_weighted);
                r.value = clamp_value(div_toward_zero(acc_weighted, 64'd1 << WEIGHT_FRAC));
                r.delta = clamp_value(div_toward_zero(num, acc_weight));
            end else begin
                q = div_toward_zero(acc_weighted, acc_weight);
                if (q > Q_LIM) q = Q_LIM;
                if (q < -Q_LIM) q = -Q_LIM;
                lam = {112'b0, lambda_q14};
                upd = div_toward_zero(q * lam, 64'd1 << LAMBDA_FRAC);
                voxel = clamp_value(base_q + upd);
                r.value = (voxel < 0) ? '0 : voxel;
            end
        end else if (w.op == OP_BWD) begin
            r.value = w.base;
        end
        acc_weighted = '0;
        acc_weight = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic t_plan_row plan_row(t_op op, logic [31:0] gv, logic [31:0] wt,
                                           logic [31:0] base, bit last, bit typed,
                                           t_op kind, logic [31:0] val, logic [31:0] dl);
        t_plan_row p;
        p.word.op = op;
        p.word.gathered = gv;
        p.word.weight = wt;
        p.word.base = base;
        p.word.last = last;
        p.typed = typed;
        p.want.kind = kind;
        p.want.value = val;
        p.want.delta = dl;
        return p;
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(VALUE_W-1){1'b1}}};
            1: return {1'b1, {(VALUE_W-1){1'b0}}};
            2, 3, 4: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_plan_row draw_word(t_op row_op, bit last_one);
        t_plan_row p;
        p.word.op = ($urandom_range(0, 7) == 0) ? t_op'($urandom_range(0, 1)) : row_op;
        p.word.gathered = draw_value();
        p.word.base = draw_value();
        case ($urandom_range(0, 5))
            0: p.word.weight = '0;
            1: p.word.weight = '1;
            2, 3: p.word.weight = $urandom_range(0, 32'h0200_0000);
            default: p.word.weight = $urandom();
        endcase
        p.word.last = last_one;
        p.typed = 1'b0;
        p.want.kind = OP_FWD;
        p.want.value = '0;
        p.want.delta = '0;
        return p;
    endfunction

    task automatic send_word(input t_plan_row p);
        t_row_result got;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= p.word.op;
        i_gathered_value <= p.word.gathered;
        i_weight <= p.word.weight;
        i_base_value <= p.word.base;
        i_last <= p.word.last;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (fold_word(p.word, got)) begin
            if (p.typed)
                got = p.want;
            results_due = {results_due, got};
        end
    endtask

    task automatic apb_rw(input bit wr, input logic [PADDR_W-1:0] addr,
                          input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_lambda(input logic [LAMBDA_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        apb_rw(1'b1, REG_LAMBDA_ADDR, {{(PDATA_W-LAMBDA_W){1'b0}}, value}, rd);
        lambda_q14 = value;
        apb_rw(1'b0, REG_LAMBDA_ADDR, '0, rd);
        check_field("lambda_gain", value, rd[LAMBDA_W-1:0]);
    endtask

    // Drop valid and hold until every row result is in and the divider is quiet.
    task automatic settle_rows();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: check each word and throttle ready in bursts
    always @(posedge i_clk) begin : drain_results
        t_row_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: row result with none expected: kind %0d value %h delta %h",
                         $time, o_row_kind, o_result_value, o_delta_value);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                check_field("row_kind", want.kind, o_row_kind);
                check_field("result_value", want.value, o_result_value);
                check_field("delta_value", want.delta, o_delta_value);
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_plan_row           plan[$];
        logic [LAMBDA_W-1:0] lambda_plan[PHASES];
        logic [PDATA_W-1:0]  rd;
        int                  words_done;
        int                  row_len;
        t_op                 row_op;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_rw(1'b0, REG_LAMBDA_ADDR, '0, rd);
        check_field("lambda_gain", LAMBDA_RESET, rd[LAMBDA_W-1:0]);

        // empty rows
        plan = {plan, plan_row(OP_FWD, 32'h0000_007B, 32'h0, 32'h5, 1, 1,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'hFFFF_FFF9, 32'h0, 32'h8000_0000, 1, 1,
                               OP_BWD, 32'h8000_0000, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'h0, 32'h0, 32'h7FFF_FFFF, 1, 1,
                               OP_BWD, 32'h7FFF_FFFF, 32'h0)};
        // unit weight rows
        plan = {plan, plan_row(OP_FWD, 32'h0001_0000, 32'h0100_0000, 32'h0003_0000, 1, 1,
                               OP_FWD, 32'h0001_0000, 32'h0002_0000)};
        plan = {plan, plan_row(OP_BWD, 32'h0002_0000, 32'h0100_0000, 32'h0001_0000, 1, 1,
                               OP_BWD, 32'h0003_0000, 32'h0)};
        // negative result clamps at zero
        plan = {plan, plan_row(OP_BWD, 32'hFFFE_0000, 32'h0100_0000, 32'h0001_0000, 1, 1,
                               OP_BWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000, 1, 1,
                               OP_BWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1, 1,
                               OP_BWD, 32'h0, 32'h0)};
        // truncation toward zero
        plan = {plan, plan_row(OP_FWD, 32'hFFFF_FFFF, 32'h0080_0000, 32'h0, 1, 1,
                               OP_FWD, 32'h0, 32'h1)};
        plan = {plan, plan_row(OP_FWD, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 1, 1,
                               OP_FWD, 32'hFFFF_FF80, 32'h7FFF_FFFF)};
        // saturation at both rails
        plan = {plan, plan_row(OP_FWD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 1,
                               OP_FWD, 32'h7FFF_FFFF, 32'h8000_0001)};
        plan = {plan, plan_row(OP_BWD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1,
                               OP_BWD, 32'h7FFF_FFFF, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 0, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_FWD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 0, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_FWD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1, 0,
                               OP_FWD, 32'h0, 32'h0)};
        // mixed op within a row, zero weight in the middle
        plan = {plan, plan_row(OP_BWD, 32'h1234_5678, 32'h0080_0000, 32'h0, 0, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_FWD, 32'h7ACE_0000, 32'h0, 32'h0, 0, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_FWD, 32'hFFFF_8000, 32'h0180_0000, 32'h0005_0000, 1, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_FWD, 32'h0001_8000, 32'h0040_0000, 32'h0, 0, 0,
                               OP_FWD, 32'h0, 32'h0)};
        plan = {plan, plan_row(OP_BWD, 32'hFFFF_0000, 32'h00C0_0000, 32'h0002_0000, 1, 0,
                               OP_FWD, 32'h0, 32'h0)};

        idling_on = 1'b1;
        foreach (plan[k])
            send_word(plan[k]);
        settle_rows();

        lambda_plan = '{16'hFFFF, 16'h0000, LAMBDA_RESET, 16'($urandom_range(0, 65535)),
                        16'h0001, 16'($urandom_range(0, 65535))};
        for (int ph = 0; ph < PHASES; ph++) begin
            set_lambda(lambda_plan[ph]);
            // run the last phase at full rate
            idling_on = (ph != PHASES - 1);
            words_done = 0;
            while (words_done < PHASE_WORDS) begin
                row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 6);
                row_op = t_op'($urandom_range(0, 1));
                for (int k = 0; k < row_len; k++)
                    send_word(draw_word(row_op, k == row_len - 1));
                words_done += row_len;
            end
            settle_rows();
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/sru_pkg.sv
design/sru_ctrl.sv
design/sru_dp.sv
design/sart_row_update.sv
design/sru_chk.sv
verif/testbench.sv
